@@ sv/ktws_pkg.sv @@
package ktws_pkg;

  localparam int NUM_KEYS    = 19;
  localparam int WINDOW_BITS = 32;

  localparam int KEY_W   = 5;
  localparam int THR_W   = 6;
  localparam int TIMER_W = 8;
  localparam int CNT_W   = $clog2(WINDOW_BITS + 1);
  localparam int CMP_W   = (CNT_W > THR_W) ? CNT_W : THR_W;

  localparam int APB_AW = 3;
  localparam int APB_DW = 32;

  localparam int S_TDATA_W = 8;
  localparam int M_TDATA_W = 8;

  localparam logic [THR_W-1:0]   THR_RESET  = THR_W'(31);
  localparam logic [TIMER_W-1:0] SUST_RESET = TIMER_W'(250);
  localparam logic [TIMER_W-1:0] SUST_MIN   = TIMER_W'(1);
  localparam logic [TIMER_W-1:0] SUST_MAX   = TIMER_W'(254);

  // register index, taken from paddr[2]
  typedef enum logic [0:0] {
    REG_THRESHOLD = 1'b0,
    REG_SUSTAIN   = 1'b1
  } reg_idx_e;

  // live configuration, sustain already clamped to its legal range
  typedef struct packed {
    logic [THR_W-1:0]   threshold;
    logic [TIMER_W-1:0] sustain;
  } cfg_t;

  typedef struct packed {
    logic             valid;
    logic [KEY_W-1:0] key;
    logic             touched;
  } sample_t;

  typedef struct packed {
    logic valid;
    logic note_on;
  } note_evt_t;

endpackage

@@ sv/ktws_cfg_regs.sv @@
module ktws_cfg_regs (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [ktws_pkg::APB_AW-1:0]  paddr,
  input  logic [ktws_pkg::APB_DW-1:0]  pwdata,
  output logic [ktws_pkg::APB_DW-1:0]  prdata,
  output logic                         pready,
  output ktws_pkg::cfg_t               cfg_o
);

  logic [ktws_pkg::THR_W-1:0]   thr_q, thr_d;
  logic [ktws_pkg::TIMER_W-1:0] sust_q, sust_d;
  logic                         wr_en;
  ktws_pkg::reg_idx_e           reg_idx;

  assign pready  = 1'b1;
  assign wr_en   = psel & penable & pwrite & pready;
  assign reg_idx = ktws_pkg::reg_idx_e'(paddr[2]);

  always_comb begin
    thr_d  = thr_q;
    sust_d = sust_q;
    if (wr_en) begin
      unique case (reg_idx)
        ktws_pkg::REG_THRESHOLD: thr_d  = pwdata[ktws_pkg::THR_W-1:0];
        ktws_pkg::REG_SUSTAIN:   sust_d = pwdata[ktws_pkg::TIMER_W-1:0];
        default:                 thr_d  = thr_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q  <= ktws_pkg::THR_RESET;
      sust_q <= ktws_pkg::SUST_RESET;
    end else begin
      thr_q  <= thr_d;
      sust_q <= sust_d;
    end
  end

  always_comb begin
    unique case (reg_idx)
      ktws_pkg::REG_THRESHOLD: prdata = ktws_pkg::APB_DW'(thr_q);
      ktws_pkg::REG_SUSTAIN:   prdata = ktws_pkg::APB_DW'(sust_q);
      default:                 prdata = '0;
    endcase
  end

  // clamp sustain to 1..254 so that sustain+1 always fits the timer
  always_comb begin
    cfg_o.threshold = thr_q;
    if (sust_q < ktws_pkg::SUST_MIN) begin
      cfg_o.sustain = ktws_pkg::SUST_MIN;
    end else if (sust_q > ktws_pkg::SUST_MAX) begin
      cfg_o.sustain = ktws_pkg::SUST_MAX;
    end else begin
      cfg_o.sustain = sust_q;
    end
  end

endmodule

@@ sv/ktws_key_update.sv @@
module ktws_key_update (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  ktws_pkg::cfg_t     cfg_i,
  input  ktws_pkg::sample_t  smp_i,
  output ktws_pkg::note_evt_t evt_o
);

  logic [ktws_pkg::WINDOW_BITS-1:0] hist_q [ktws_pkg::NUM_KEYS];
  logic [ktws_pkg::CNT_W-1:0]       cnt_q  [ktws_pkg::NUM_KEYS];
  logic [ktws_pkg::TIMER_W-1:0]     tmr_q  [ktws_pkg::NUM_KEYS];

  logic                             in_range;
  logic                             upd;
  logic [ktws_pkg::WINDOW_BITS-1:0] hist_rd, hist_d;
  logic [ktws_pkg::CNT_W-1:0]       cnt_rd, cnt_d;
  logic [ktws_pkg::TIMER_W-1:0]     tmr_rd, tmr_d;
  logic [ktws_pkg::TIMER_W-1:0]     sust_p1;
  logic                             oldest;
  logic                             qualify;

  assign in_range = smp_i.key < ktws_pkg::KEY_W'(ktws_pkg::NUM_KEYS);
  assign upd      = smp_i.valid & in_range;

  always_comb begin
    hist_rd = '0;
    cnt_rd  = '0;
    tmr_rd  = '0;
    if (in_range) begin
      hist_rd = hist_q[smp_i.key];
      cnt_rd  = cnt_q[smp_i.key];
      tmr_rd  = tmr_q[smp_i.key];
    end
  end

  assign oldest  = hist_rd[ktws_pkg::WINDOW_BITS-1];
  assign hist_d  = {hist_rd[ktws_pkg::WINDOW_BITS-2:0], smp_i.touched};
  assign sust_p1 = cfg_i.sustain + ktws_pkg::TIMER_W'(1);

  always_comb begin
    cnt_d = cnt_rd;
    if (smp_i.touched && !oldest) begin
      cnt_d = cnt_rd + ktws_pkg::CNT_W'(1);
    end else if (!smp_i.touched && oldest && (cnt_rd != '0)) begin
      cnt_d = cnt_rd - ktws_pkg::CNT_W'(1);
    end
  end

  assign qualify = ktws_pkg::CMP_W'(cnt_d) > ktws_pkg::CMP_W'(cfg_i.threshold);

  always_comb begin
    tmr_d = tmr_rd;
    if (smp_i.touched) begin
      if (qualify) begin
        tmr_d = (tmr_rd != '0) ? cfg_i.sustain : sust_p1;
      end
    end else if (tmr_rd != '0) begin
      tmr_d = tmr_rd - ktws_pkg::TIMER_W'(1);
    end
  end

  // note-on wins over note-off
  always_comb begin
    evt_o.valid   = 1'b0;
    evt_o.note_on = 1'b0;
    if (upd) begin
      if (tmr_d == sust_p1) begin
        evt_o.valid   = 1'b1;
        evt_o.note_on = 1'b1;
      end else if (tmr_d == ktws_pkg::TIMER_W'(1)) begin
        evt_o.valid = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < ktws_pkg::NUM_KEYS; k++) begin
        hist_q[k] <= '0;
        cnt_q[k]  <= '0;
        tmr_q[k]  <= '0;
      end
    end else if (upd) begin
      hist_q[smp_i.key] <= hist_d;
      cnt_q[smp_i.key]  <= cnt_d;
      tmr_q[smp_i.key]  <= tmr_d;
    end
  end

  a_count_matches_window: assert property (@(posedge clk_i) disable iff (!rst_ni)
    upd |-> ($countones(hist_rd) == int'(cnt_rd)))
    else $error("touch count out of step with window");

  a_no_event_out_of_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (smp_i.valid && !in_range) |-> !evt_o.valid)
    else $error("event for key outside the key range");

  a_qualified_touch_arms_timer: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (upd && smp_i.touched && qualify) |=> (tmr_q[$past(smp_i.key)] != '0))
    else $error("qualified touch left timer idle");

endmodule

@@ sv/key_touch_window_sustain_unit.sv @@
// Per-key touch debounce with note sustain. Each input word carries one touch sample
// for one key; the block keeps a 32-sample window and touched-sample count per key and
// a sustain timer, and emits a note-on word when a key's count exceeds the threshold
// with its timer idle (timer loaded to sustain+1) and a note-off word when set to 1.
// Keys at or above the key count are dropped without effect. Throughput is one word
// per cycle unless the output register stalls: a sample sits in the input register,
// the per-key read-modify-write of history, count and timer completes from it in the
// same cycle that it advances, and any event is loaded into the output register.
// Only the output register back-pressures the input, and the input register still
// takes one more word while an event waits. Config via APB: threshold at 0x0 (6 bits,
// reset 31), sustain at 0x4 (8 bits, reset 250, used as 1..254); write only while idle.
module key_touch_window_sustain_unit (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  // sample stream
  input  logic                             s_axis_tvalid,
  output logic                             s_axis_tready,
  input  logic [ktws_pkg::S_TDATA_W-1:0]   s_axis_tdata,  // key_index[4:0], touched[5]
  // event stream
  output logic                             m_axis_tvalid,
  input  logic                             m_axis_tready,
  output logic [ktws_pkg::M_TDATA_W-1:0]   m_axis_tdata,  // event_key[4:0]
  output logic                             m_axis_tuser,  // note_on[0]
  // config port
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [ktws_pkg::APB_AW-1:0]      paddr,
  input  logic [ktws_pkg::APB_DW-1:0]      pwdata,
  output logic [ktws_pkg::APB_DW-1:0]      prdata,
  output logic                             pready
);

  ktws_pkg::cfg_t      cfg;
  ktws_pkg::sample_t   smp;
  ktws_pkg::note_evt_t evt;

  // input register
  logic                         in_vld_q, in_vld_d;
  logic [ktws_pkg::KEY_W-1:0]   in_key_q, in_key_d;
  logic                         in_tch_q, in_tch_d;

  // output register
  logic                         out_vld_q, out_vld_d;
  logic [ktws_pkg::KEY_W-1:0]   out_key_q, out_key_d;
  logic                         out_on_q, out_on_d;

  logic                         s_acc;
  logic                         adv;

  ktws_cfg_regs u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  // the held word moves on when the output register is free or being emptied
  assign adv           = in_vld_q & (~out_vld_q | m_axis_tready);
  assign s_axis_tready = ~in_vld_q | adv;
  assign s_acc         = s_axis_tvalid & s_axis_tready;

  assign smp.valid   = adv;
  assign smp.key     = in_key_q;
  assign smp.touched = in_tch_q;

  ktws_key_update u_upd (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg),
    .smp_i  (smp),
    .evt_o  (evt)
  );

  always_comb begin
    in_vld_d = in_vld_q;
    in_key_d = in_key_q;
    in_tch_d = in_tch_q;
    if (s_acc) begin
      in_vld_d = 1'b1;
      in_key_d = s_axis_tdata[ktws_pkg::KEY_W-1:0];
      in_tch_d = s_axis_tdata[ktws_pkg::KEY_W];
    end else if (adv) begin
      in_vld_d = 1'b0;
    end
  end

  always_comb begin
    out_vld_d = out_vld_q;
    out_key_d = out_key_q;
    out_on_d  = out_on_q;
    if (adv) begin
      out_vld_d = evt.valid;
      if (evt.valid) begin
        out_key_d = in_key_q;
        out_on_d  = evt.note_on;
      end
    end else if (m_axis_tready) begin
      out_vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      in_vld_q  <= in_vld_d;
      out_vld_q <= out_vld_d;
    end
  end

  // payload, no reset needed
  always_ff @(posedge clk_i) begin
    in_key_q  <= in_key_d;
    in_tch_q  <= in_tch_d;
    out_key_q <= out_key_d;
    out_on_q  <= out_on_d;
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = ktws_pkg::M_TDATA_W'(out_key_q);
  assign m_axis_tuser  = out_on_q;

  a_held_word_kept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_vld_q && !adv) |=> (in_vld_q && $stable(in_key_q) && $stable(in_tch_q)))
    else $error("pending sample overwritten");

  a_event_from_update: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!out_vld_q ##1 out_vld_q) |-> $past(adv && evt.valid))
    else $error("event word appeared without a sample update");

  a_event_key_matches: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (adv && evt.valid) |=> (out_vld_q && (out_key_q == $past(in_key_q))))
    else $error("event word lost or carries wrong key");

endmodule
